// ===== rtl/sha256_pkg.sv =====
// Shared types, constants and the rotate function for the SHA-256 digest block
`default_nettype none
package sha256_pkg;

   localparam int WordWidth = 32;
   localparam int NumRounds = 64;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_PAD,
      ST_LEN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_DATA,
      WR_ZERO,
      WR_LEN
   } wr_sel_type;

   typedef struct packed {
      wr_sel_type wr_sel;
      logic       wr_first_pad;
      logic       add_len;
      logic       start_block;
      logic       round_step;
      logic       load_chain;
      logic       emit_step;
      logic       restart;
   } cmd_type;

   typedef struct packed {
      logic       last_round;
      logic       buffer_full;
      logic       fill_past_pad;
      logic [5:0] fill;
      logic       last_emit;
   } status_type;

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PadByte   = 8'h80;
   localparam logic [5:0] LenOffset = 6'd56;

   function automatic logic [31:0] ror(input logic [31:0] v, input int n);
      ror = (v >> n) | (v << (32 - n));
   endfunction

endpackage
`default_nettype wire

// ===== rtl/sha256_ctrl.sv =====
// Sequencer for byte loading, padding, compression rounds and digest output
`default_nettype none
module sha256_ctrl
   import sha256_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output cmd_type         cmd,
   input  wire status_type status
);

   state_type state_ff, state_in;
   logic      finish_ff, finish_in;
   logic      pad_done_ff, pad_done_in;
   logic      len_next_ff, len_next_in;
   logic      accept;

   assign accept = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         finish_ff   <= 1'b0;
         pad_done_ff <= 1'b0;
         len_next_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         finish_ff   <= finish_in;
         pad_done_ff <= pad_done_in;
         len_next_ff <= len_next_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      finish_in   = finish_ff;
      pad_done_in = pad_done_ff;
      len_next_in = len_next_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               finish_in   = req_data.end_of_message;
               pad_done_in = 1'b0;
               if (req_data.byte_valid && status.buffer_full) begin
                  state_in = ST_ROUND;
               end else if (req_data.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            if (status.last_round) begin
               if (!finish_ff) begin
                  state_in = ST_IDLE;
               end else if (len_next_ff) begin
                  state_in    = ST_EMIT;
                  len_next_in = 1'b0;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            pad_done_in = 1'b1;
            if (!pad_done_ff) begin
               if (status.fill == 6'd63) begin
                  state_in = ST_ROUND;
               end else if (status.fill_past_pad) begin
                  state_in = ST_PAD;
               end else if (status.fill == LenOffset - 6'd1) begin
                  state_in = ST_LEN;
               end
            end else if (status.fill == 6'd63) begin
               state_in = ST_ROUND;
            end else if (status.fill == LenOffset - 6'd1) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (status.fill == 6'd63) begin
               state_in    = ST_ROUND;
               len_next_in = 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp_ready && status.last_emit) begin
               state_in  = ST_IDLE;
               finish_in = 1'b0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept && req_data.byte_valid) begin
               cmd.wr_sel      = WR_DATA;
               cmd.start_block = status.buffer_full;
            end
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            cmd.load_chain = status.last_round;
         end
         ST_PAD: begin
            cmd.wr_sel       = WR_ZERO;
            cmd.wr_first_pad = !pad_done_ff;
            cmd.start_block  = status.fill == 6'd63;
         end
         ST_LEN: begin
            cmd.wr_sel      = WR_LEN;
            cmd.start_block = status.fill == 6'd63;
         end
         ST_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.emit_step = rsp_ready;
            cmd.restart   = rsp_ready & status.last_emit;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/sha256_datapath.sv =====
// Block buffer, message schedule, round registers and chaining hash
`default_nettype none
module sha256_datapath
   import sha256_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output status_type   status,
   output rsp_type      rsp_data
);

   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [31:0] chain_ff [8];
   logic [31:0] s_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0]  round_ff;
   logic [2:0]  emit_ff;
   logic [7:0]  wr_byte;
   logic        wr_en;
   logic [31:0] w_new, t1, t2, e, a;
   logic [2:0]  len_idx;

   assign len_idx = fill_ff[2:0];
   assign wr_en   = cmd.wr_sel != WR_NONE;

   always_comb begin
      unique case (cmd.wr_sel)
         WR_DATA: wr_byte = req_data.data_byte;
         WR_ZERO: wr_byte = cmd.wr_first_pad ? PadByte : 8'h00;
         WR_LEN:  wr_byte = bits_ff[63 - 8 * len_idx -: 8];
         default: wr_byte = 8'h00;
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      bits_in = bits_ff;
      if (wr_en) begin
         fill_in = fill_ff + 6'd1;
      end
      if (cmd.wr_sel == WR_DATA) begin
         bits_in = bits_ff + 64'd8;
      end
      if (cmd.restart) begin
         fill_in = '0;
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bits_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         bits_ff <= bits_in;
      end
   end

   assign w_new = (ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10))
                + w_ff[9]
                + (ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3))
                + w_ff[0];
   assign e  = s_ff[4];
   assign a  = s_ff[0];
   assign t1 = s_ff[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
             + ((e & s_ff[5]) ^ (~e & s_ff[6])) + RoundK[round_ff] + w_ff[0];
   assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
             + ((a & s_ff[1]) ^ (a & s_ff[2]) ^ (s_ff[1] & s_ff[2]));

   // shift bytes in big-endian; after 64 bytes the words hold the block
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= {w_ff[i][23:0], w_ff[i + 1][31:24]};
         end
         w_ff[15] <= {w_ff[15][23:0], wr_byte};
      end else if (cmd.round_step) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= w_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_block) begin
         for (int i = 0; i < 8; i++) begin
            s_ff[i] <= chain_ff[i];
         end
      end else if (cmd.round_step) begin
         s_ff[7]  <= s_ff[6];
         s_ff[6]  <= s_ff[5];
         s_ff[5]  <= s_ff[4];
         s_ff[4]  <= s_ff[3] + t1;
         s_ff[3]  <= s_ff[2];
         s_ff[2]  <= s_ff[1];
         s_ff[1]  <= s_ff[0];
         s_ff[0]  <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
         emit_ff  <= '0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= InitHash[i];
         end
      end else begin
         if (cmd.start_block) begin
            round_ff <= '0;
         end else if (cmd.round_step) begin
            round_ff <= round_ff + 6'd1;
         end
         if (cmd.load_chain) begin
            chain_ff[0] <= chain_ff[0] + t1 + t2;
            chain_ff[1] <= chain_ff[1] + s_ff[0];
            chain_ff[2] <= chain_ff[2] + s_ff[1];
            chain_ff[3] <= chain_ff[3] + s_ff[2];
            chain_ff[4] <= chain_ff[4] + s_ff[3] + t1;
            chain_ff[5] <= chain_ff[5] + s_ff[4];
            chain_ff[6] <= chain_ff[6] + s_ff[5];
            chain_ff[7] <= chain_ff[7] + s_ff[6];
         end
         if (cmd.emit_step) begin
            emit_ff <= emit_ff + 3'd1;
         end
         if (cmd.restart) begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= InitHash[i];
            end
         end
      end
   end

   assign status.last_round    = round_ff == 6'(NumRounds - 1);
   assign status.buffer_full   = fill_ff == 6'd63;
   assign status.fill_past_pad = fill_ff >= LenOffset;
   assign status.fill          = fill_ff;
   assign status.last_emit     = emit_ff == 3'd7;

   assign rsp_data.digest_word = chain_ff[emit_ff];
   assign rsp_data.word_index  = emit_ff;
   assign rsp_data.last_word   = emit_ff == 3'd7;

endmodule
`default_nettype wire

// ===== rtl/sha256_message_digest.sv =====
// SHA-256 digest over a byte stream: top level joining sequencer and datapath
// A byte that does not fill the block is accepted while the sequencer stays idle.
// A full block loads the working registers with its last byte, then runs 64 rounds of the shared round unit.
// End of message: padding bytes at one per cycle, one or two blocks, then 8 digest beats.
// Reset is synchronous and active high; it loads the initial hash and clears counters.
`default_nettype none
module sha256_message_digest
   import sha256_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type    cmd;
   status_type status;

   sha256_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   sha256_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ===== tb/sha256_digest_scoreboard.sv =====
// Scoreboard class: SHA-256 digest predictor and queue of expected digest beats
class sha256_digest_scoreboard;
   logic [31:0] chain [8];
   logic [7:0]  blk [64];
   int unsigned fill;
   logic [63:0] msg_bits;
   sha256_pkg::rsp_type digest_q [$];
   int unsigned errors;
   int unsigned beats_seen;
   int unsigned digests_seen;

   function new();
      errors = 0;
      beats_seen = 0;
      digests_seen = 0;
      restart_hash();
   endfunction

   function void restart_hash();
      for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::InitHash[i];
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      fill = 0;
      msg_bits = '0;
   endfunction

   function automatic logic [31:0] rot(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function void compress();
      logic [31:0] w [64];
      logic [31:0] s [8];
      logic [31:0] t1, t2, x, y;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         x = w[i-15];
         y = w[i-2];
         w[i] = (rot(y, 17) ^ rot(y, 19) ^ (y >> 10)) + w[i-7]
              + (rot(x, 7) ^ rot(x, 18) ^ (x >> 3)) + w[i-16];
      end
      for (int i = 0; i < 8; i++) s[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
         t1 = s[7] + (rot(s[4], 6) ^ rot(s[4], 11) ^ rot(s[4], 25))
            + ((s[4] & s[5]) ^ (~s[4] & s[6])) + sha256_pkg::RoundK[i] + w[i];
         t2 = (rot(s[0], 2) ^ rot(s[0], 13) ^ rot(s[0], 22))
            + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
         s[7] = s[6]; s[6] = s[5]; s[5] = s[4];
         s[4] = s[3] + t1;
         s[3] = s[2]; s[2] = s[1]; s[1] = s[0];
         s[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + s[i];
   endfunction

   function void note_request(sha256_pkg::req_type r);
      sha256_pkg::rsp_type e;
      if (r.byte_valid) begin
         blk[fill] = r.data_byte;
         msg_bits = msg_bits + 64'd8;
         fill = (fill + 1) % 64;
         if (fill == 0) compress();
      end
      if (!r.end_of_message) return;
      blk[fill] = sha256_pkg::PadByte;
      fill++;
      if (fill > 56) begin
         while (fill < 64) blk[fill++] = 8'h00;
         compress();
         fill = 0;
      end
      while (fill < 56) blk[fill++] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56+i] = msg_bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
         e.digest_word = chain[i];
         e.word_index = i[2:0];
         e.last_word = (i == 7);
         digest_q = {digest_q, e};
      end
      restart_hash();
   endfunction

   function void check_beat(sha256_pkg::rsp_type got);
      sha256_pkg::rsp_type e;
      beats_seen++;
      if (digest_q.size() == 0) begin
         $display("%0t: unexpected beat, expected none, actual %h", $time, got);
         errors++;
         return;
      end
      e = digest_q.pop_front();
      if (got.last_word) digests_seen++;
      if (got.digest_word !== e.digest_word) begin
         $display("%0t: digest_word expected %h actual %h", $time, e.digest_word,
                  got.digest_word);
         errors++;
      end
      if (got.word_index !== e.word_index) begin
         $display("%0t: word_index expected %0d actual %0d", $time, e.word_index,
                  got.word_index);
         errors++;
      end
      if (got.last_word !== e.last_word) begin
         $display("%0t: last_word expected %0d actual %0d", $time, e.last_word,
                  got.last_word);
         errors++;
      end
   endfunction
endclass

// ===== tb/tb_top.sv =====
// Top-level testbench: drives byte beats into the SHA-256 block and checks digest beats
module tb_top;
   import sha256_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   sha256_digest_scoreboard board;
   req_type stim_q [$];
   bit sending_done;
   bit hold_off_done;

   sha256_message_digest dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic add_item(logic [7:0] b, logic v, logic eom);
      req_type r;
      r.data_byte = b;
      r.byte_valid = v;
      r.end_of_message = eom;
      stim_q = {stim_q, r};
   endtask

   task automatic add_message(int len);
      for (int i = 0; i < len; i++)
         add_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1));
      if (len == 0) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic build_stimulus();
      // directed: empty, idle noise, field extremes
      add_item(8'hff, 1'b0, 1'b1);
      add_item(8'h00, 1'b0, 1'b0);
      add_item(8'hff, 1'b0, 1'b0);
      add_item(8'h00, 1'b1, 1'b1);
      add_item(8'hff, 1'b1, 1'b0);
      add_item(8'h5a, 1'b0, 1'b0);
      add_item(8'ha5, 1'b0, 1'b1);
      add_item(8'h61, 1'b1, 1'b0);
      add_item(8'h62, 1'b1, 1'b0);
      add_item(8'h63, 1'b1, 1'b1);
      // one full data block, then a tail of 56 bytes that spills the padding
      add_message(120);
   endtask

   task automatic drive_requests();
      int burst;
      while (stim_q.size() != 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && stim_q.size() != 0) begin
            @(negedge clock);
            req_valid <= 1'b1;
            req_data <= stim_q[0];
            @(posedge clock);
            while (!req_ready) @(posedge clock);
            board.note_request(stim_q.pop_front());
            burst--;
         end
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      sending_done = 1'b1;
   endtask

   initial begin
      int pattern;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      // hold off long enough for the block to back up
      repeat (400) @(negedge clock);
      hold_off_done = 1'b1;
      forever begin
         pattern = $urandom_range(0, 3);
         repeat ($urandom_range(1, 20)) begin
            @(negedge clock);
            case (pattern)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_beat(rsp_data);
   end

   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      board = new();
      sending_done = 1'b0;
      hold_off_done = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      build_stimulus();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      drive_requests();
      while (board.digest_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Checked %0d digests in %0d beats, from the empty message to three blocks.",
               board.digests_seen, board.beats_seen);
      if (board.errors == 0 && board.digest_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
